/* hw/rtl/bdc_pkg.sv */
// bdc_pkg: transaction types, fixed-point formats and elaboration-time constant
// builders (atan table, pi, CORDIC gain terms) for the GCJ-02/BD-09 converter.
// No dependencies.
package bdc_pkg;

	localparam int COORD_W   = 36;
	localparam int DP_W      = 64;   // datapath word: coordinates and angles
	localparam int GUARD_BITS = 24;
	localparam int ANG_FRAC  = 60;

	typedef struct packed {
		logic                      func;
		logic signed [COORD_W-1:0] lat_in;
		logic signed [COORD_W-1:0] lon_in;
	} coord_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] lat_out;
		logic signed [COORD_W-1:0] lon_out;
	} coord_rsp_t;

	// restoring divide, used only while elaborating constants
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem  = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/n) in radians, ANG_FRAC fraction bits, truncated series
	function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
		logic [63:0]        p;
		logic [63:0]        t;
		logic signed [63:0] s;
		p = udiv64(64'd1 << ANG_FRAC, n);
		s = '0;
		for (int k = 0; k < 64; k++) begin
			if (p != 0) begin
				t = udiv64(p, 64'(2 * k + 1));
				if (k % 2 == 1) s = s - signed'(t);
				else s = s + signed'(t);
				p = udiv64(udiv64(p, n), n);
			end
		end
		return s;
	endfunction

	function automatic logic signed [63:0] quarter_pi();
		return 4 * atan_recip(64'd5) - atan_recip(64'd239);
	endfunction

	localparam logic signed [63:0] ANG_PI      = 4 * quarter_pi();
	localparam logic signed [63:0] ANG_HALF_PI = 2 * quarter_pi();

	function automatic logic signed [63:0] atan_entry(input int i);
		if (i == 0) return quarter_pi();
		return atan_recip(64'd1 << ((i < 47) ? i : 47));
	endfunction

	// 1/K^2 over n CORDIC iterations, ANG_FRAC fraction bits
	function automatic logic [63:0] kinv2_of(input int n);
		logic [63:0] k;
		k = 64'd1 << ANG_FRAC;
		for (int i = 0; i < 64; i++) begin
			if (i < n && 2 * i <= 61) k = k - udiv64(k, (64'd1 << (2 * i)) + 64'd1);
		end
		return k;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// angle perturbation amplitude pre-scaled by 1/K
	function automatic logic signed [63:0] ang_term_of(input int n);
		logic [127:0] p;
		logic [63:0]  pang;
		pang = udiv64((64'd3 << 55) + 64'd15625, 64'd31250);
		p = 128'(pang) * 128'(isqrt64(kinv2_of(n)));
		return signed'(p[93:30]);
	endfunction

	function automatic logic signed [63:0] mag_term_of(input int frac);
		return signed'(udiv64((64'd1 << (frac + GUARD_BITS - 3)) + 64'd3125, 64'd6250));
	endfunction

	function automatic logic signed [63:0] off_lat_of(input int frac);
		return signed'(udiv64((64'd3 << frac) + 64'd250, 64'd500));
	endfunction

	function automatic logic signed [63:0] off_lon_of(input int frac);
		return signed'(udiv64((64'd13 << frac) + 64'd1000, 64'd2000));
	endfunction

endpackage

/* hw/rtl/bdc_pimul.sv */
// bdc_pimul: two-stage pi * (value mod 2 degrees) angle generator.
// Depends on bdc_pkg.
module bdc_pimul import bdc_pkg::*; #(
	parameter int FRAC_BITS = 26,
	parameter int SIDE_W    = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_i,
	input  logic signed [DP_W-1:0] v_i,
	input  logic [SIDE_W-1:0]      side_i,
	output logic                   vld_o,
	output logic signed [DP_W-1:0] z_o,
	output logic [SIDE_W-1:0]      side_o
);
	localparam int UW = FRAC_BITS + 1;
	localparam int PW = UW + 32;
	localparam int FW = UW + 64;
	localparam logic [63:0] PI_U = 64'(ANG_PI);

	logic [UW-1:0] u;
	logic [UW-1:0] m;
	logic          neg;
	logic [FW-1:0] full;
	logic [63:0]   r;

	logic              vld_s1, vld_s2;
	logic              neg_s1;
	logic [PW-1:0]     plo_s1, phi_s1;
	logic [SIDE_W-1:0] side_s1, side_s2;
	logic signed [DP_W-1:0] z_s2;

	assign u   = v_i[UW-1:0];
	assign neg = u[UW-1];
	assign m   = neg ? (~u + UW'(1)) : u;

	assign full = FW'(plo_s1) + (FW'(phi_s1) << 32);
	assign r    = full[FRAC_BITS+63:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg;
			plo_s1  <= PW'(m) * PW'(PI_U[31:0]);
			phi_s1  <= PW'(m) * PW'(PI_U[63:32]);
			side_s1 <= side_i;
			z_s2    <= neg_s1 ? -signed'(r) : signed'(r);
			side_s2 <= side_s1;
		end
	end

	assign vld_o  = vld_s2;
	assign z_o    = z_s2;
	assign side_o = side_s2;
endmodule

/* hw/rtl/bdc_cordic.sv */
// bdc_cordic: pipelined CORDIC, one register stage per iteration plus a
// quadrant pre-step stage. Vectoring or rotation mode. Depends on bdc_pkg.
module bdc_cordic import bdc_pkg::*; #(
	parameter int STAGES    = 28,
	parameter bit VECTORING = 1'b0,
	parameter int SIDE_W    = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_i,
	input  logic signed [DP_W-1:0] x_i,
	input  logic signed [DP_W-1:0] y_i,
	input  logic signed [DP_W-1:0] z_i,
	input  logic [SIDE_W-1:0]      side_i,
	output logic                   vld_o,
	output logic signed [DP_W-1:0] x_o,
	output logic signed [DP_W-1:0] y_o,
	output logic signed [DP_W-1:0] z_o,
	output logic [SIDE_W-1:0]      side_o
);
	logic                   vld_s  [0:STAGES];
	logic signed [DP_W-1:0] x_s    [0:STAGES];
	logic signed [DP_W-1:0] y_s    [0:STAGES];
	logic signed [DP_W-1:0] z_s    [0:STAGES];
	logic [SIDE_W-1:0]      side_s [0:STAGES];

	logic signed [DP_W-1:0] x0, y0, z0;

	// pre-step: fold the vector or angle into the convergence range
	always_comb begin
		x0 = x_i;
		y0 = y_i;
		z0 = z_i;
		if (VECTORING) begin
			if (x_i < 0) begin
				z0 = (y_i >= 0) ? ANG_PI : -ANG_PI;
				x0 = -x_i;
				y0 = -y_i;
			end
		end else begin
			if (z_i > ANG_HALF_PI) begin
				z0 = z_i - ANG_PI;
				x0 = -x_i;
			end else if (z_i < -ANG_HALF_PI) begin
				z0 = z_i + ANG_PI;
				x0 = -x_i;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x0;
			y_s[0]    <= y0;
			z_s[0]    <= z0;
			side_s[0] <= side_i;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_iter
		localparam logic signed [DP_W-1:0] AT = atan_entry(k);
		logic signed [DP_W-1:0] dx, dy;
		logic                   d;

		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;
		assign d  = VECTORING ? (y_s[k] >= 0) : (z_s[k] >= 0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (VECTORING == d) begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
				end else begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
				end
				if (VECTORING == d) z_s[k+1] <= z_s[k] + AT;
				else z_s[k+1] <= z_s[k] - AT;
			end
		end
	end

	assign vld_o  = vld_s[STAGES];
	assign x_o    = x_s[STAGES];
	assign y_o    = y_s[STAGES];
	assign z_o    = z_s[STAGES];
	assign side_o = side_s[STAGES];
endmodule

/* hw/rtl/bdc_finish.sv */
// bdc_finish: 1/K^2 gain removal (split 64x64 multiply), rounding to the
// output format, offset add and saturation; five stages. Depends on bdc_pkg.
module bdc_finish import bdc_pkg::*; #(
	parameter logic [63:0] KINV2 = 64'd0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_i,
	input  logic signed [DP_W-1:0]    v_i,
	input  logic signed [DP_W-1:0]    off_i,
	output logic                      vld_o,
	output logic signed [COORD_W-1:0] r_o
);
	localparam logic signed [DP_W-1:0] SAT_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam logic signed [DP_W-1:0] SAT_LO = -(64'sd1 <<< (COORD_W - 1));
	localparam logic signed [DP_W-1:0] RND    = 64'sd1 <<< (GUARD_BITS - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic neg_s1, neg_s2, neg_s3;
	logic [63:0] m_s1;
	logic [63:0] pp00_s2, pp01_s2, pp10_s2, pp11_s2;
	logic [63:0] r_s3;
	logic signed [DP_W-1:0] s_s4;
	logic signed [DP_W-1:0] off_s1, off_s2, off_s3, off_s4;
	logic signed [COORD_W-1:0] res_s5;

	logic [127:0] prod;
	logic signed [DP_W-1:0] t;
	logic signed [COORD_W-1:0] sat;

	assign prod = {64'd0, pp00_s2} + ({64'd0, pp01_s2} << 32) + ({64'd0, pp10_s2} << 32)
		+ {pp11_s2, 64'd0};

	assign t = (s_s4 >>> GUARD_BITS) + off_s4;

	always_comb begin
		if (t > SAT_HI) sat = SAT_HI[COORD_W-1:0];
		else if (t < SAT_LO) sat = SAT_LO[COORD_W-1:0];
		else sat = t[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= v_i < 0;
			m_s1    <= (v_i < 0) ? unsigned'(-v_i) : unsigned'(v_i);
			off_s1  <= off_i;
			pp00_s2 <= 64'(m_s1[31:0]) * 64'(KINV2[31:0]);
			pp01_s2 <= 64'(m_s1[31:0]) * 64'(KINV2[63:32]);
			pp10_s2 <= 64'(m_s1[63:32]) * 64'(KINV2[31:0]);
			pp11_s2 <= 64'(m_s1[63:32]) * 64'(KINV2[63:32]);
			neg_s2  <= neg_s1;
			off_s2  <= off_s1;
			r_s3    <= prod[ANG_FRAC+63:ANG_FRAC];
			neg_s3  <= neg_s2;
			off_s3  <= off_s2;
			s_s4    <= (neg_s3 ? -signed'(r_s3) : signed'(r_s3)) + RND;
			off_s4  <= off_s3;
			res_s5  <= sat;
		end
	end

	assign vld_o = vld_s5;
	assign r_o   = res_s5;
endmodule

/* hw/rtl/bd09_coordinate_convert.sv */
// GCJ-02 <-> BD-09 coordinate converter, fully pipelined: one transaction per
// cycle in, one per cycle out while rsp_ready keeps up. Stages: input stage,
// two pi-argument multiply stages, a CORDIC of CORDIC_STAGES+1 stages for the
// polar form and both perturbations in parallel, a combine stage, the final
// rotation CORDIC and five output stages. Throughput is set by the single
// pipeline advance: the whole pipe moves when the output register is empty or
// being taken, so cmd_ready drops only while a result is held by rsp_ready.
// Coordinates are signed Q(35-FRAC_BITS).FRAC_BITS degrees; func=0 converts
// GCJ-02 to BD-09, func=1 the reverse. Results saturate at the 36-bit limits.
// Depends on bdc_pkg, bdc_pimul, bdc_cordic and bdc_finish.
module bd09_coordinate_convert import bdc_pkg::*; #(
	parameter int FRAC_BITS     = 26,
	parameter int CORDIC_STAGES = 28
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  coord_req_t cmd,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output coord_rsp_t rsp
);
	localparam logic signed [DP_W-1:0] OFF_LAT  = off_lat_of(FRAC_BITS);
	localparam logic signed [DP_W-1:0] OFF_LON  = off_lon_of(FRAC_BITS);
	localparam logic signed [DP_W-1:0] MAG_TERM = mag_term_of(FRAC_BITS);
	localparam logic signed [DP_W-1:0] ANG_TERM = ang_term_of(CORDIC_STAGES);
	localparam logic [63:0]            KINV2    = kinv2_of(CORDIC_STAGES);
	localparam int SIDE_W = 1 + 2 * DP_W;

	// global pipeline advance
	logic adv;
	assign adv       = !rsp_valid || rsp_ready;
	assign cmd_ready = adv;

	// input stage: sign-extend, strip BD-09 offsets on the reverse path
	logic signed [DP_W-1:0] lat_x, lon_x;
	logic                   vld_s1, rev_s1;
	logic signed [DP_W-1:0] lat_s1, lon_s1;

	assign lat_x = {{(DP_W-COORD_W){cmd.lat_in[COORD_W-1]}}, cmd.lat_in};
	assign lon_x = {{(DP_W-COORD_W){cmd.lon_in[COORD_W-1]}}, cmd.lon_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rev_s1 <= cmd.func;
			lat_s1 <= cmd.func ? lat_x - OFF_LAT : lat_x;
			lon_s1 <= cmd.func ? lon_x - OFF_LON : lon_x;
		end
	end

	// pi-scaled arguments; the lat unit carries the transaction along
	logic                   vld_pa;
	logic signed [DP_W-1:0] zlat_pa, zlon_pa;
	logic [SIDE_W-1:0]      side_pa;

	bdc_pimul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_pimul_lat (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_s1), .v_i(lat_s1), .side_i({rev_s1, lat_s1, lon_s1}),
		.vld_o(vld_pa), .z_o(zlat_pa), .side_o(side_pa)
	);

	bdc_pimul #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_pimul_lon (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_s1), .v_i(lon_s1), .side_i(1'b0),
		.vld_o(), .z_o(zlon_pa), .side_o()
	);

	logic                   rev_pa;
	logic signed [DP_W-1:0] lat_pa, lon_pa;
	assign {rev_pa, lat_pa, lon_pa} = side_pa;

	// polar form of the input point
	logic                   vld_v, rev_v;
	logic signed [DP_W-1:0] mag_v, ang_v;

	bdc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1), .SIDE_W(1)) u_polar (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_pa), .x_i(lon_pa <<< GUARD_BITS), .y_i(lat_pa <<< GUARD_BITS),
		.z_i('0), .side_i(rev_pa),
		.vld_o(vld_v), .x_o(mag_v), .y_o(), .z_o(ang_v), .side_o(rev_v)
	);

	// magnitude perturbation: MAG_TERM * sin(pi*lat)
	logic signed [DP_W-1:0] ps_v;

	bdc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(1)) u_sin (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_pa), .x_i(MAG_TERM), .y_i('0), .z_i(zlat_pa), .side_i(1'b0),
		.vld_o(), .x_o(), .y_o(ps_v), .z_o(), .side_o()
	);

	// angle perturbation: ANG_TERM * cos(pi*lon)
	logic signed [DP_W-1:0] pc_v;

	bdc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(1)) u_cos (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_pa), .x_i(ANG_TERM), .y_i('0), .z_i(zlon_pa), .side_i(1'b0),
		.vld_o(), .x_o(pc_v), .y_o(), .z_o(), .side_o()
	);

	// apply perturbations in polar form
	logic                   vld_sc, rev_sc;
	logic signed [DP_W-1:0] mag_sc, ang_sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc <= 1'b0;
		end else if (adv) begin
			vld_sc <= vld_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rev_sc <= rev_v;
			mag_sc <= rev_v ? mag_v - ps_v : mag_v + ps_v;
			ang_sc <= rev_v ? ang_v - pc_v : ang_v + pc_v;
		end
	end

	// back to cartesian
	logic                   vld_r, rev_r;
	logic signed [DP_W-1:0] xr, yr;

	bdc_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(1)) u_rect (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_sc), .x_i(mag_sc), .y_i('0), .z_i(ang_sc), .side_i(rev_sc),
		.vld_o(vld_r), .x_o(xr), .y_o(yr), .z_o(), .side_o(rev_r)
	);

	// gain removal, rounding, BD-09 offsets on the forward path, saturation
	logic signed [COORD_W-1:0] lat_f, lon_f;

	bdc_finish #(.KINV2(KINV2)) u_fin_lat (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_r), .v_i(yr), .off_i(rev_r ? '0 : OFF_LAT),
		.vld_o(rsp_valid), .r_o(lat_f)
	);

	bdc_finish #(.KINV2(KINV2)) u_fin_lon (
		.clk, .arst_n, .en(adv),
		.vld_i(vld_r), .v_i(xr), .off_i(rev_r ? '0 : OFF_LON),
		.vld_o(), .r_o(lon_f)
	);

	assign rsp.lat_out = lat_f;
	assign rsp.lon_out = lon_f;
endmodule

/* tb/tb_bd09_coordinate_convert.sv */
// Testbench for bd09_coordinate_convert: directed and random GCJ-02/BD-09 conversions
// checked against a bit-exact CORDIC predictor held in a small scoreboard class.
// Depends on bdc_pkg (transaction types) and the converter RTL.
module tb_bd09_coordinate_convert;
	import bdc_pkg::*;

	localparam int FRAC       = 26;
	localparam int STAGES     = 28;
	localparam int LATENCY    = 2 * STAGES + 11;
	localparam int STALL_LIMIT = 4000;
	localparam logic FUNC_TO_BD  = 1'b0;
	localparam logic FUNC_TO_GCJ = 1'b1;

	// expected-result store plus the fixed-point conversion predictor
	class coord_scoreboard;
		coord_rsp_t             expected_q[$];
		int                     errors;
		int                     matched;
		longint                 atan_tab[STAGES];
		longint                 ang_pi;
		longint                 ang_half_pi;
		longint unsigned        gain_inv2;
		longint unsigned        gain_inv30;

		function new();
			longint q;
			errors  = 0;
			matched = 0;
			q = 4 * atan_inv(5) - atan_inv(239);
			ang_pi      = 4 * q;
			ang_half_pi = 2 * q;
			atan_tab[0] = q;
			for (int i = 1; i < STAGES; i++) atan_tab[i] = atan_inv(64'd1 << i);
			gain_inv2 = 64'd1 << ANG_FRAC;
			for (int i = 0; i < STAGES; i++)
				gain_inv2 -= gain_inv2 / ((64'd1 << (2 * i)) + 64'd1);
			gain_inv30 = isqrt(gain_inv2);
		endfunction

		static function longint atan_inv(longint unsigned n);
			longint unsigned p;
			longint          s;
			longint unsigned k;
			p = (64'd1 << ANG_FRAC) / n;
			s = 0;
			k = 0;
			while (p != 0) begin
				if (k[0]) s -= longint'(p / (2 * k + 1));
				else s += longint'(p / (2 * k + 1));
				p = p / n / n;
				k++;
			end
			return s;
		endfunction

		static function longint unsigned isqrt(longint unsigned v_in);
			longint unsigned v, r, b;
			v = v_in;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		static function longint unsigned mul_shr(longint unsigned a, longint unsigned b, int s);
			logic [127:0] p;
			p = 128'(a) * 128'(b);
			p = p >> s;
			return p[63:0];
		endfunction

		// sign-magnitude product, truncates toward zero
		static function longint mul_trunc(longint a, longint unsigned b, int s);
			longint unsigned m;
			longint unsigned r;
			m = (a < 0) ? -a : a;
			r = mul_shr(m, b, s);
			return (a < 0) ? -longint'(r) : longint'(r);
		endfunction

		function void to_polar(longint x_in, longint y_in, output longint mag,
				output longint ang);
			longint x, y, z, dx, dy;
			x = x_in;
			y = y_in;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? ang_pi : -ang_pi;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_tab[i];
				end else begin
					x -= dx; y += dy; z -= atan_tab[i];
				end
			end
			mag = x;
			ang = z;
		endfunction

		function void rotate(longint x_in, longint z_in, output longint xo, output longint yo);
			longint x, y, z, dx, dy;
			x = x_in;
			y = 0;
			z = z_in;
			if (z > ang_half_pi) begin
				z -= ang_pi; x = -x;
			end else if (z < -ang_half_pi) begin
				z += ang_pi; x = -x;
			end
			for (int i = 0; i < STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_tab[i];
				end else begin
					x += dx; y -= dy; z += atan_tab[i];
				end
			end
			xo = x;
			yo = y;
		endfunction

		// pi times the coordinate folded into [-1,1) degrees
		function longint pi_angle(longint v);
			longint unsigned u;
			longint          w;
			u = longint'(v) & ((64'd1 << (FRAC + 1)) - 1);
			w = (u >= (64'd1 << FRAC)) ? longint'(u) - (longint'(1) << (FRAC + 1)) : longint'(u);
			return mul_trunc(w, ang_pi, FRAC);
		endfunction

		function logic signed [COORD_W-1:0] round_sat(longint v, longint off);
			longint r;
			longint hi;
			hi = (longint'(1) << (COORD_W - 1)) - 1;
			r = ((mul_trunc(v, gain_inv2, ANG_FRAC) + (longint'(1) << (GUARD_BITS - 1)))
				>>> GUARD_BITS) + off;
			if (r > hi) r = hi;
			if (r < -hi - 1) r = -hi - 1;
			return r[COORD_W-1:0];
		endfunction

		function void note_request(coord_req_t req);
			longint     lat, lon, mag, th, ps, pc, xr, yr, unused;
			longint     off_lat, off_lon, mag_amp;
			longint unsigned ang_amp;
			coord_rsp_t exp_rsp;
			off_lat = ((64'd3 << FRAC) + 250) / 500;
			off_lon = ((64'd13 << FRAC) + 1000) / 2000;
			mag_amp = ((64'd1 << (FRAC + GUARD_BITS - 3)) + 3125) / 6250;
			ang_amp = ((64'd3 << 55) + 15625) / 31250;
			lat = req.lat_in;
			lon = req.lon_in;
			if (req.func == FUNC_TO_GCJ) begin
				lat -= off_lat;
				lon -= off_lon;
			end
			to_polar(lon <<< GUARD_BITS, lat <<< GUARD_BITS, mag, th);
			rotate(mag_amp, pi_angle(lat), unused, ps);
			rotate(longint'(mul_shr(ang_amp, gain_inv30, 30)), pi_angle(lon), pc, unused);
			if (req.func == FUNC_TO_GCJ) begin
				mag -= ps; th -= pc;
			end else begin
				mag += ps; th += pc;
			end
			rotate(mag, th, xr, yr);
			exp_rsp.lon_out = round_sat(xr, (req.func == FUNC_TO_GCJ) ? 0 : off_lon);
			exp_rsp.lat_out = round_sat(yr, (req.func == FUNC_TO_GCJ) ? 0 : off_lat);
			expected_q.push_back(exp_rsp);
		endfunction

		function void check_result(coord_rsp_t got);
			coord_rsp_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result lat_out %0d lon_out %0d", got.lat_out, got.lon_out);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.lat_out !== want.lat_out) begin
				$error("lat_out: expected %0d, got %0d", want.lat_out, got.lat_out);
				errors++;
			end
			if (got.lon_out !== want.lon_out) begin
				$error("lon_out: expected %0d, got %0d", want.lon_out, got.lon_out);
				errors++;
			end
			matched++;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_ready;
	coord_req_t cmd;
	logic       rsp_valid;
	logic       rsp_ready;
	coord_rsp_t rsp;

	coord_scoreboard sb;
	int tx_idle_pct;     // chance per cycle of a sender gap
	int rx_idle_pct;     // chance per cycle of receiver stall
	int stall_cycles;
	int sent_count;

	bd09_coordinate_convert #(.FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Receiver side: ready toggles on the falling edge, results checked on the rising edge.
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
	end

	// Watchdog: counts cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One transaction on the command channel; called and returns at a falling edge.
	task automatic send_point(logic func, logic signed [COORD_W-1:0] lat,
			logic signed [COORD_W-1:0] lon);
		coord_req_t req;
		req.func   = func;
		req.lat_in = lat;
		req.lon_in = lon;
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= req;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_request(req);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] deg(real d);
		return COORD_W'(longint'(d * (2.0 ** FRAC)));
	endfunction

	// Mostly points inside China's map area, some anywhere in the field range.
	task automatic random_points(int count);
		logic signed [COORD_W-1:0] lat, lon;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 70) begin
				lat = COORD_W'(longint'(deg(18.0)) + longint'($urandom_range(36 * 1024))
					* (longint'(1) << (FRAC - 10)));
				lon = COORD_W'(longint'(deg(73.0)) + longint'($urandom_range(62 * 1024))
					* (longint'(1) << (FRAC - 10)));
				lat += COORD_W'($urandom_range((1 << (FRAC - 10)) - 1));
				lon += COORD_W'($urandom_range((1 << (FRAC - 10)) - 1));
			end else begin
				lat = COORD_W'({$urandom, $urandom});
				lon = COORD_W'({$urandom, $urandom});
			end
			send_point(1'($urandom_range(1)), lat, lon);
		end
	endtask

	initial begin
		logic signed [COORD_W-1:0] max_c, min_c, off_lat, off_lon;
		sb = new();
		arst_n       = 1'b0;
		cmd_valid    = 1'b0;
		cmd          = '0;
		rsp_ready    = 1'b0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		stall_cycles = 0;
		sent_count   = 0;
		max_c   = {1'b0, {(COORD_W-1){1'b1}}};
		min_c   = {1'b1, {(COORD_W-1){1'b0}}};
		off_lat = COORD_W'(((64'd3 << FRAC) + 250) / 500);
		off_lon = COORD_W'(((64'd13 << FRAC) + 1000) / 2000);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, both directions, special cases
		send_point(FUNC_TO_BD, 0, 0);                         // zero vector
		send_point(FUNC_TO_GCJ, off_lat, off_lon);            // zero vector after offsets
		send_point(FUNC_TO_BD, 0, -deg(5.0));                 // negative x, zero y
		send_point(FUNC_TO_GCJ, off_lat, off_lon - deg(7.25));
		send_point(FUNC_TO_GCJ, off_lat + 1, off_lon);        // one-LSB latitude after offsets
		send_point(FUNC_TO_GCJ, off_lat + deg(0.5), off_lon + 3);
		send_point(FUNC_TO_BD, max_c, max_c);                 // saturation
		send_point(FUNC_TO_BD, min_c, min_c);
		send_point(FUNC_TO_GCJ, max_c, min_c);
		send_point(FUNC_TO_GCJ, min_c, max_c);
		send_point(FUNC_TO_BD, max_c, 0);
		send_point(FUNC_TO_BD, 0, min_c);
		send_point(FUNC_TO_GCJ, -1, -1);
		send_point(FUNC_TO_BD, deg(39.915), deg(116.404));
		send_point(FUNC_TO_GCJ, deg(39.921), deg(116.410));
		send_point(FUNC_TO_BD, deg(1.0), deg(-1.0));          // fold boundaries of the sine argument
		send_point(FUNC_TO_BD, deg(-1.0), deg(2.0) - 1);
		send_point(FUNC_TO_GCJ, deg(-22.5), deg(-113.9));

		// hold off until the pipeline has emptied completely
		drain();
		@(negedge clk);

		tx_idle_pct = 38; rx_idle_pct = 71;
		random_points(180);
		tx_idle_pct = 71; rx_idle_pct = 38;
		random_points(180);
		tx_idle_pct = 0;  rx_idle_pct = 0;
		random_points(190);

		drain();
		repeat (LATENCY + 8) @(negedge clk);
		$display("Converted %0d coordinate pairs in both directions, %0d results compared.",
			sent_count, sb.matched);
		$display("Covered field extremes, saturation, zero vectors and random map points.");
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
